### rtl/fsd_pkg.sv
// Shared types, constants and table functions of the RGB332 error-diffusion ditherer.
`timescale 1ns / 1ps

package fsd_pkg;

   // Line store geometry
   localparam int MAX_WIDTH    = 1024;
   localparam int COL_BITS     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int BANK_BITS    = (COL_BITS > 1) ? COL_BITS - 1 : 1;
   localparam int BANK_DEPTH   = (MAX_WIDTH + 1) / 2;

   // Frame geometry
   localparam int HEIGHT_LIMIT = 4096;
   localparam int ROW_BITS     = 12;

   // Register file
   localparam int WIDTH_BITS     = 11;
   localparam int HEIGHT_BITS    = 13;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_WIDTH   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [WIDTH_BITS-1:0]     LINE_WIDTH_RESET   = 11'd640;
   localparam logic [HEIGHT_BITS-1:0]    FRAME_HEIGHT_RESET = 13'd480;

   // Channels, in store word order from the low end
   localparam int NUM_CH   = 3;
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   // Error shares stay within +-33, so 8 signed bits per channel
   localparam int ERR_BITS  = 8;
   localparam int WORD_BITS = NUM_CH * ERR_BITS;

   typedef logic [NUM_CH-1:0][7:0]          pixel_type;
   typedef logic [NUM_CH-1:0][ERR_BITS-1:0] err3_type;

   // Position of a pixel in the frame, resolved at acceptance
   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic                first_row;
      logic                last_col;
      logic                last_row;
   } pos_type;

   // Handshake events of the pixel stage
   typedef struct packed {
      logic accept;
      logic fire;
   } stage_ctl_type;

   // One write into a line store bank
   typedef struct packed {
      logic                 en;
      logic [BANK_BITS-1:0] addr;
      err3_type             data;
   } bank_wr_type;

   // Palette level for a 3-bit red or green code: (k*255+3)/7
   function automatic logic [7:0] level_rg(input logic [2:0] k);
      logic [7:0] lv;
      case (k)
         3'd0:    lv = 8'd0;
         3'd1:    lv = 8'd36;
         3'd2:    lv = 8'd73;
         3'd3:    lv = 8'd109;
         3'd4:    lv = 8'd146;
         3'd5:    lv = 8'd182;
         3'd6:    lv = 8'd219;
         default: lv = 8'd255;
      endcase
      return lv;
   endfunction

   // Palette level for a 2-bit blue code: (k*255+1)/3
   function automatic logic [7:0] level_b(input logic [1:0] k);
      logic [7:0] lv;
      case (k)
         2'd0:    lv = 8'd0;
         2'd1:    lv = 8'd85;
         2'd2:    lv = 8'd170;
         default: lv = 8'd255;
      endcase
      return lv;
   endfunction

   // Signed divide by 16, truncating toward zero
   function automatic logic [ERR_BITS-1:0] div16(input logic signed [10:0] x);
      logic signed [10:0] b;
      b = x + (x[10] ? 11'sd15 : 11'sd0);
      return ERR_BITS'(b >>> 4);
   endfunction

endpackage

### rtl/fsd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module fsd_ram #(
   parameter int DEPTH     = 512,
   parameter int ADDR_BITS = 9,
   parameter int DATA_BITS = 24
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fsd_pos.sv
// Column and row counters that place each accepted pixel in the frame.
`timescale 1ns / 1ps

module fsd_pos (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [fsd_pkg::COL_BITS-1:0] w_m1,
   input  logic [fsd_pkg::ROW_BITS-1:0] h_m1,
   output fsd_pkg::pos_type             pos
);

   import fsd_pkg::*;

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col;

   // a column past a narrowed line counts as the last one
   always_comb begin
      col           = (col_ff > w_m1) ? w_m1 : col_ff;
      pos.col       = col;
      pos.last_col  = (col == w_m1);
      pos.last_row  = (row_ff >= h_m1);
      pos.first_row = (row_ff == '0);
   end

   // raster advance, wrap at frame end
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (pos.last_col) begin
            col_in = '0;
            row_in = pos.last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### rtl/fsd_diffuse.sv
// Pixel stage: adds carried and stored error, quantizes, spreads the new error.
`timescale 1ns / 1ps

module fsd_diffuse (
   input  logic                  clock,
   input  logic                  reset,
   input  fsd_pkg::stage_ctl_type ctl,
   input  fsd_pkg::pixel_type    pixel,
   input  fsd_pkg::pos_type      pos_new,
   input  fsd_pkg::err3_type     rd_even,
   input  fsd_pkg::err3_type     rd_odd,
   output logic [7:0]            color_index,
   output fsd_pkg::bank_wr_type  even_wr,
   output fsd_pkg::bank_wr_type  odd_wr
);

   import fsd_pkg::*;

   // pixel held in the stage
   pixel_type pix_ff;
   pos_type   pos_ff;
   logic      fwd_hit_ff, fwd_hit_in;
   err3_type  fwd_data_ff, fwd_data_in;

   // row carries
   err3_type carry_ff, carry_in;
   err3_type pend_left_ff, pend_left_in;
   err3_type pend_here_ff, pend_here_in;

   err3_type            store;
   err3_type            left_data, here_data;
   pixel_type           val_q;
   logic                left_en, here_en;
   logic [COL_BITS-1:0] left_col;

   // stored error: a write in the cycle of the read is forwarded
   assign store = fwd_hit_ff ? fwd_data_ff : (pos_ff.col[0] ? rd_odd : rd_even);

   // per-channel quantize and error split
   always_comb begin
      logic signed [9:0]  raw;
      logic signed [9:0]  sum;
      logic [7:0]         val;
      logic [7:0]         level;
      logic signed [8:0]  e;
      logic signed [10:0] ex;
      logic [ERR_BITS-1:0] sh7, sh5, sh3, sh1;
      carry_in     = carry_ff;
      pend_left_in = pend_left_ff;
      pend_here_in = pend_here_ff;
      left_data    = '0;
      here_data    = '0;
      val_q        = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         raw = $signed({2'b00, pix_ff[ch]});
         sum = raw + 10'($signed(carry_ff[ch]))
             + (pos_ff.first_row ? 10'sd0 : 10'($signed(store[ch])));
         if (sum[9]) begin
            val = 8'd0;
         end else if (sum > 10'sd255) begin
            val = 8'd255;
         end else begin
            val = sum[7:0];
         end
         level = (ch == CH_BLUE) ? level_b(val[7:6]) : level_rg(val[7:5]);
         e     = $signed({1'b0, val}) - $signed({1'b0, level});
         ex    = 11'(e);
         sh7   = div16(ex * 11'sd7);
         sh5   = div16(ex * 11'sd5);
         sh3   = div16(ex * 11'sd3);
         sh1   = div16(ex);
         val_q[ch]     = val;
         carry_in[ch]  = pos_ff.last_col ? '0 : sh7;
         left_data[ch] = pend_left_ff[ch] + sh3;
         here_data[ch] = pend_here_ff[ch] + sh5;
         if (pos_ff.last_row || pos_ff.last_col) begin
            pend_left_in[ch] = '0;
            pend_here_in[ch] = '0;
         end else begin
            pend_left_in[ch] = here_data[ch];
            pend_here_in[ch] = sh1;
         end
      end
   end

   assign color_index = {val_q[CH_RED][7:5], val_q[CH_GREEN][7:5], val_q[CH_BLUE][7:6]};

   // store writes: below-left column, and this column at the right edge
   assign left_col = pos_ff.col - 1'b1;
   assign left_en  = ctl.fire && !pos_ff.last_row && (pos_ff.col != '0);
   assign here_en  = ctl.fire && !pos_ff.last_row && pos_ff.last_col;

   // the two columns differ in parity, so each bank sees at most one write
   always_comb begin
      if (pos_ff.col[0]) begin
         even_wr.en   = left_en;
         even_wr.addr = BANK_BITS'(left_col >> 1);
         even_wr.data = left_data;
         odd_wr.en    = here_en;
         odd_wr.addr  = BANK_BITS'(pos_ff.col >> 1);
         odd_wr.data  = here_data;
      end else begin
         even_wr.en   = here_en;
         even_wr.addr = BANK_BITS'(pos_ff.col >> 1);
         even_wr.data = here_data;
         odd_wr.en    = left_en;
         odd_wr.addr  = BANK_BITS'(left_col >> 1);
         odd_wr.data  = left_data;
      end
   end

   // forward match against the column being read for the next pixel
   always_comb begin
      fwd_hit_in  = 1'b0;
      fwd_data_in = left_data;
      if (here_en && (pos_ff.col == pos_new.col)) begin
         fwd_hit_in  = 1'b1;
         fwd_data_in = here_data;
      end else if (left_en && (left_col == pos_new.col)) begin
         fwd_hit_in  = 1'b1;
      end
   end

   // stage load
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         pix_ff      <= pixel;
         pos_ff      <= pos_new;
         fwd_data_ff <= fwd_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff   <= 1'b0;
         carry_ff     <= '0;
         pend_left_ff <= '0;
         pend_here_ff <= '0;
      end else begin
         if (ctl.accept) begin
            fwd_hit_ff <= fwd_hit_in;
         end
         if (ctl.fire) begin
            carry_ff     <= carry_in;
            pend_left_ff <= pend_left_in;
            pend_here_ff <= pend_here_in;
         end
      end
   end

endmodule

### rtl/floyd_steinberg_rgb332_dither.sv
// Top level of the RGB332 error-diffusion ditherer: registers, line store, handshakes.
//
// Pixels arrive on the req_ channel in raster order (valid/stall, taken when
// req_valid is high and req_stall low); one palette index word per pixel
// leaves on the rsp_ channel, red in bits 7:5, green in 4:2, blue in 1:0.
// Line width and frame height are written through the csr_ port; the user must
// do so only while no pixel is in flight, which the block itself does not enforce.
// A taken pixel passes the pixel stage, then the output register that shows
// its result word. Throughput: one pixel per clock while the receiver does not
// stall, set by the carry loop to the next pixel and by one line-store write
// per bank per pixel (the store is split by column parity into two banks).
// The line store is read when a pixel is taken, its data registered with the
// pixel stage; a write to the entry being read in that cycle is forwarded.
// Reset clears the counters, the row carries and the output valid flag and
// sets 640 x 480; the line store is not cleared, since row zero ignores it.
// A stalled receiver holds the output register; one more pixel is taken into
// the pixel stage, then req_stall rises until the output word is taken.
`timescale 1ns / 1ps

module floyd_steinberg_rgb332_dither (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [fsd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fsd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_red,
   input  logic [7:0]                         req_green,
   input  logic [7:0]                         req_blue,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_color_index
);

   import fsd_pkg::*;

   logic [WIDTH_BITS-1:0]  line_width_ff, line_width_in;
   logic [HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;
   logic [COL_BITS-1:0]    w_m1;
   logic [ROW_BITS-1:0]    h_m1;

   logic          stage_valid_ff, stage_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_index_ff;
   stage_ctl_type ctl;

   pos_type             pos_new;
   pixel_type           pixel;
   logic [7:0]          color_index;
   bank_wr_type         even_wr, odd_wr;
   logic [WORD_BITS-1:0] rd_even, rd_odd;
   logic [BANK_BITS-1:0] rd_addr;

   // register writes
   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:   line_width_in   = csr_wdata[WIDTH_BITS-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[HEIGHT_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // effective last column and last row: zero acts as one, large values saturate
   always_comb begin
      if (line_width_ff == '0) begin
         w_m1 = '0;
      end else if (32'(line_width_ff) > MAX_WIDTH) begin
         w_m1 = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         w_m1 = COL_BITS'(line_width_ff - 1'b1);
      end
      if (frame_height_ff == '0) begin
         h_m1 = '0;
      end else if (frame_height_ff > HEIGHT_BITS'(HEIGHT_LIMIT)) begin
         h_m1 = ROW_BITS'(HEIGHT_LIMIT - 1);
      end else begin
         h_m1 = ROW_BITS'(frame_height_ff - 1'b1);
      end
   end

   // handshake: pixel stage feeds the output register
   always_comb begin
      ctl.fire       = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall      = stage_valid_ff && !ctl.fire;
      ctl.accept     = req_valid && !req_stall;
      stage_valid_in = ctl.accept || (stage_valid_ff && !ctl.fire);
      rsp_valid_in   = ctl.fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         rsp_index_ff <= color_index;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_index_ff;

   // pixel position
   fsd_pos u_pos (
      .clock   (clock),
      .reset   (reset),
      .advance (ctl.accept),
      .w_m1    (w_m1),
      .h_m1    (h_m1),
      .pos     (pos_new)
   );

   // line store, even and odd columns
   assign rd_addr = BANK_BITS'(pos_new.col >> 1);

   fsd_ram #(
      .DEPTH     (BANK_DEPTH),
      .ADDR_BITS (BANK_BITS),
      .DATA_BITS (WORD_BITS)
   ) u_ram_even (
      .clock   (clock),
      .wr_en   (even_wr.en),
      .wr_addr (even_wr.addr),
      .wr_data (even_wr.data),
      .rd_en   (ctl.accept),
      .rd_addr (rd_addr),
      .rd_data (rd_even)
   );

   fsd_ram #(
      .DEPTH     (BANK_DEPTH),
      .ADDR_BITS (BANK_BITS),
      .DATA_BITS (WORD_BITS)
   ) u_ram_odd (
      .clock   (clock),
      .wr_en   (odd_wr.en),
      .wr_addr (odd_wr.addr),
      .wr_data (odd_wr.data),
      .rd_en   (ctl.accept),
      .rd_addr (rd_addr),
      .rd_data (rd_odd)
   );

   // pixel stage
   assign pixel = {req_red, req_green, req_blue};

   fsd_diffuse u_diffuse (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .pixel       (pixel),
      .pos_new     (pos_new),
      .rd_even     (rd_even),
      .rd_odd      (rd_odd),
      .color_index (color_index),
      .even_wr     (even_wr),
      .odd_wr      (odd_wr)
   );

endmodule

### rtl/fsd_checker.sv
// Port-level checks of the ditherer, bound to its top level.
`timescale 1ns / 1ps

module fsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_color_index
);

   logic [2:0] inflight_ff, inflight_in;
   logic       req_take, rsp_take;

   // words taken in minus words delivered
   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_take && !rsp_take) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_color_index)))
      else $error("stalled result word changed");

   // only the pixel stage and the output register hold words
   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd2)
      else $error("more words in flight than stages");

   // nothing in flight: no result shown and input open
   a_empty_open: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == 3'd0) |-> (!rsp_valid && !req_stall))
      else $error("empty block stalls or shows a result");

endmodule

bind floyd_steinberg_rgb332_dither fsd_checker u_checker (.*);
